@@ sv/phi_pkg.sv @@
package phi_pkg;

    localparam int LEN_W       = 8;
    localparam int SUM_W       = 32;
    localparam int COEF_W      = 22;
    localparam int FAC_W       = 17;
    localparam int KNEE_W      = 26;
    localparam int HYDRO_W     = 27;
    localparam int NUM_LETTERS = 26;
    localparam int NT_SLOTS    = 4;
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = 2;
    localparam int Q_CNT_W     = 3;

    localparam logic [7:0]        LETTER_A   = 8'd65;
    localparam logic [7:0]        LETTER_Z   = 8'd90;
    localparam logic [1:0]        NT_NONE    = 2'd3;
    localparam logic [KNEE_W-1:0] KNEE_RESET = 26'd2490368;
    localparam logic [31:0]       RECIP10    = 32'hCCCCCCCD;

    localparam int RC_TENTHS [NUM_LETTERS] = '{
        8, 0, -8, -5, 0, 105, -9, -13, 84, 0, -19, 96, 58,
        -12, 0, 2, -9, -13, -8, 4, 0, 50, 110, 0, 40, 0};
    localparam int RCNT_TENTHS [NUM_LETTERS] = '{
        -15, 0, 40, 90, 70, -70, 50, 40, -80, 0, 46, -90, -55,
        50, 0, 40, 10, 80, 50, 50, 0, -55, -40, 0, -30, 0};
    localparam int NT_HUNDREDTHS [3] = '{42, 22, 5};

    typedef struct packed {
        logic signed [SUM_W-1:0] sum;
        logic [LEN_W-1:0]        count;
        logic                    bad_letter;
        logic                    too_long;
    } phi_pep_t;

    function automatic int rnd_div10(int num);
        int res;
        if (num >= 0)
        begin
            res = (num + 5) / 10;
        end
        else
        begin
            res = -((-num + 5) / 10);
        end
        return res;
    endfunction

    function automatic int rnd_div1000(int num);
        int res;
        if (num >= 0)
        begin
            res = (num + 500) / 1000;
        end
        else
        begin
            res = -((-num + 500) / 1000);
        end
        return res;
    endfunction

    // Q16 contribution of one letter; slot 3 means past the N-terminal window.
    function automatic int coef_q16(int k, int p);
        int v;
        v = rnd_div10(RC_TENTHS[k] * 65536);
        if (p < 3)
        begin
            v = v + rnd_div1000(NT_HUNDREDTHS[p] * RCNT_TENTHS[k] * 65536);
        end
        return v;
    endfunction

endpackage

@@ sv/phi_if.sv @@
interface phi_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] residue_letter;
    logic       last_residue;

    modport source (output valid, output residue_letter, output last_residue, input ready);
    modport sink (input valid, input residue_letter, input last_residue, output ready);
endinterface

interface phi_out_if;
    logic               valid;
    logic               ready;
    logic signed [26:0] hydro_q16;
    logic               bad_letter;
    logic               too_long;

    modport source (output valid, output hydro_q16, output bad_letter, output too_long,
                    input ready);
    modport sink (input valid, input hydro_q16, input bad_letter, input too_long,
                  output ready);
endinterface

interface phi_cfg_if;
    logic        valid;
    logic        ready;
    logic [25:0] knee_q16;

    modport source (output valid, output knee_q16, input ready);
    modport sink (input valid, input knee_q16, output ready);
endinterface

@@ sv/peptide_hydrophobicity_index.sv @@
// A result beat is offered once the last residue's beat is queued, popped and scaled.
// One residue beat per cycle is accepted while the 4-entry peptide queue is not full;
// it absorbs short-peptide bursts, as the back end scales one peptide at a time.
// Its pop, multiply, round, knee, divide, output steps run one per cycle unless stalled.
// Reset clears the running sum, count, flags, queue and out valid; knee resets to 38.0.
module peptide_hydrophobicity_index
    import phi_pkg::*;
#(
    parameter int MAX_LEN = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    phi_in_if.sink    residue_in,
    phi_cfg_if.sink   cfg,
    phi_out_if.source result_out
);

    logic [KNEE_W-1:0] knee_reg;
    logic              push;
    phi_pep_t          push_data;
    logic              q_full;
    logic              q_empty;
    logic              pop;
    phi_pep_t          pop_data;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            knee_reg <= KNEE_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            knee_reg <= cfg.knee_q16;
        end
    end

    phi_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .residue_in (residue_in),
        .push       (push),
        .push_data  (push_data),
        .q_full     (q_full)
    );

    phi_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    phi_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .knee       (knee_reg),
        .q_empty    (q_empty),
        .pop_data   (pop_data),
        .pop        (pop),
        .result_out (result_out)
    );

endmodule

@@ sv/phi_queue.sv @@
module phi_queue
    import phi_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     push,
    input  phi_pep_t push_data,
    output logic     full,
    input  logic     pop,
    output phi_pep_t pop_data,
    output logic     empty
);

    phi_pep_t             mem_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_CNT_W-1:0]   cnt_reg;
    logic                 do_push;
    logic                 do_pop;

    assign full     = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign empty    = (cnt_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ sv/phi_front.sv @@
module phi_front
    import phi_pkg::*;
#(
    parameter int MAX_LEN = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    phi_in_if.sink    residue_in,
    output logic      push,
    output phi_pep_t  push_data,
    input  logic      q_full
);

    localparam logic [LEN_W-1:0] MAX_CNT = LEN_W'(MAX_LEN);

    logic signed [COEF_W-1:0] coef_tab [NUM_LETTERS][NT_SLOTS];

    for (genvar gk = 0; gk < NUM_LETTERS; gk++)
    begin : g_letter
        for (genvar gp = 0; gp < NT_SLOTS; gp++)
        begin : g_slot
            localparam int C = coef_q16(gk, gp);
            assign coef_tab[gk][gp] = COEF_W'(C);
        end
    end

    logic signed [SUM_W-1:0] sum_reg;
    logic signed [SUM_W-1:0] sum_next;
    logic [LEN_W-1:0]        count_reg;
    logic [LEN_W-1:0]        count_next;
    logic                    bad_reg;
    logic                    bad_next;
    logic                    long_reg;
    logic                    long_next;
    logic                    beat;
    logic                    letter_ok;
    logic [7:0]              letter_off;
    logic [1:0]              slot;
    logic signed [COEF_W-1:0] add;
    logic signed [SUM_W:0]   sum_wide;

    assign residue_in.ready = !q_full;
    assign beat = residue_in.valid && residue_in.ready;

    assign letter_ok  = (residue_in.residue_letter >= LETTER_A) &&
                        (residue_in.residue_letter <= LETTER_Z);
    assign letter_off = residue_in.residue_letter - LETTER_A;
    assign slot       = (count_reg < LEN_W'(3)) ? count_reg[1:0] : NT_NONE;
    assign add        = letter_ok ? coef_tab[letter_off[4:0]][slot] : '0;

    always_comb
    begin
        sum_wide = (SUM_W + 1)'(sum_reg) + (SUM_W + 1)'(add);
        if (sum_wide[SUM_W:SUM_W-1] == 2'b01)
        begin
            sum_next = {1'b0, {(SUM_W - 1){1'b1}}};
        end
        else if (sum_wide[SUM_W:SUM_W-1] == 2'b10)
        begin
            sum_next = {1'b1, {(SUM_W - 1){1'b0}}};
        end
        else
        begin
            sum_next = sum_wide[SUM_W-1:0];
        end
        bad_next = bad_reg || !letter_ok;
        if (count_reg < MAX_CNT)
        begin
            count_next = count_reg + 1'b1;
            long_next  = long_reg;
        end
        else
        begin
            count_next = count_reg;
            long_next  = 1'b1;
        end
    end

    assign push                 = beat && residue_in.last_residue;
    assign push_data.sum        = sum_next;
    assign push_data.count      = count_next;
    assign push_data.bad_letter = bad_next;
    assign push_data.too_long   = long_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg   <= '0;
            count_reg <= '0;
            bad_reg   <= 1'b0;
            long_reg  <= 1'b0;
        end
        else if (beat)
        begin
            if (residue_in.last_residue)
            begin
                sum_reg   <= '0;
                count_reg <= '0;
                bad_reg   <= 1'b0;
                long_reg  <= 1'b0;
            end
            else
            begin
                sum_reg   <= sum_next;
                count_reg <= count_next;
                bad_reg   <= bad_next;
                long_reg  <= long_next;
            end
        end
    end

endmodule

@@ sv/phi_back.sv @@
module phi_back
    import phi_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [KNEE_W-1:0] knee,
    input  logic              q_empty,
    input  phi_pep_t          pop_data,
    output logic              pop,
    phi_out_if.source         result_out
);

    localparam int PROD_W = 50;
    localparam int H_W    = 33;
    localparam int E_W    = 28;
    localparam int T_W    = 31;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_RND  = 3'd2;
    localparam logic [2:0] S_KNEE = 3'd3;
    localparam logic [2:0] S_DIV  = 3'd4;
    localparam logic [2:0] S_FIN  = 3'd5;

    localparam logic signed [H_W-1:0] H_MAX = H_W'(67108863);
    localparam logic signed [H_W-1:0] H_MIN = -H_W'(67108864);
    localparam logic [E_W-1:0]        E_CAP = E_W'(134217728);

    logic [FAC_W-1:0] fac_rom [1 << LEN_W];

    for (genvar g = 0; g < (1 << LEN_W); g++)
    begin : g_fac
        localparam int DEN = 1000 + 15 * (g - 20);
        localparam int F   = (g < 10) ? (((1000 - 27 * (10 - g)) * 65536 + 500) / 1000) :
                             (g > 20) ? ((65536000 + DEN / 2) / DEN) : 65536;
        assign fac_rom[g] = FAC_W'(F);
    end

    logic [2:0]                state_reg;
    logic [2:0]                state_next;
    logic signed [SUM_W-1:0]   sum_reg;
    logic [FAC_W-1:0]          fac_reg;
    logic                      bad_reg;
    logic                      long_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [H_W-1:0]     h_reg;
    logic                      ge_reg;
    logic [T_W-1:0]            t_reg;
    logic [HYDRO_W-1:0]        q_reg;
    logic                      out_valid_reg;
    logic signed [HYDRO_W-1:0] hydro_reg;
    logic                      out_bad_reg;
    logic                      out_long_reg;

    logic signed [PROD_W-1:0]  prod_full;
    logic [PROD_W-1:0]         prod_mag;
    logic [PROD_W-1:0]         prod_rnd;
    logic [H_W-1:0]            h_mag;
    logic signed [H_W-1:0]     h_round;
    logic signed [H_W-1:0]     knee_ext;
    logic signed [H_W-1:0]     excess;
    logic [E_W-1:0]            e_cap;
    logic [62:0]               div_prod;
    logic [HYDRO_W+1:0]        knee_sum;
    logic signed [HYDRO_W-1:0] hydro_fin;
    logic                      fin_go;

    assign pop    = (state_reg == S_IDLE) && !q_empty;
    assign fin_go = (state_reg == S_FIN) && (!out_valid_reg || result_out.ready);

    assign prod_full = PROD_W'(sum_reg) * PROD_W'($signed({1'b0, fac_reg}));
    assign prod_mag  = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
    assign prod_rnd  = prod_mag + PROD_W'(32768);
    assign h_mag     = prod_rnd[H_W+15:16];
    assign h_round   = prod_reg[PROD_W-1] ? -$signed(h_mag) : $signed(h_mag);

    assign knee_ext = $signed({{(H_W - KNEE_W){1'b0}}, knee});
    assign excess   = h_reg - knee_ext;
    assign e_cap    = (excess > $signed(H_W'(E_CAP))) ? E_CAP : excess[E_W-1:0];
    assign div_prod = {32'b0, t_reg} * {31'b0, RECIP10};
    assign knee_sum = (HYDRO_W + 2)'(knee) + (HYDRO_W + 2)'(q_reg);

    always_comb
    begin
        if (ge_reg)
        begin
            if (knee_sum > (HYDRO_W + 2)'(67108863))
            begin
                hydro_fin = H_MAX[HYDRO_W-1:0];
            end
            else
            begin
                hydro_fin = knee_sum[HYDRO_W-1:0];
            end
        end
        else if (h_reg > H_MAX)
        begin
            hydro_fin = H_MAX[HYDRO_W-1:0];
        end
        else if (h_reg < H_MIN)
        begin
            hydro_fin = H_MIN[HYDRO_W-1:0];
        end
        else
        begin
            hydro_fin = h_reg[HYDRO_W-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:  state_next = S_RND;
            S_RND:  state_next = S_KNEE;
            S_KNEE: state_next = S_DIV;
            S_DIV:  state_next = S_FIN;
            S_FIN:
            begin
                if (fin_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fin_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            sum_reg  <= pop_data.sum;
            fac_reg  <= fac_rom[pop_data.count];
            bad_reg  <= pop_data.bad_letter;
            long_reg <= pop_data.too_long;
        end
        if (state_reg == S_MUL)
        begin
            prod_reg <= prod_full;
        end
        if (state_reg == S_RND)
        begin
            h_reg <= h_round;
        end
        if (state_reg == S_KNEE)
        begin
            ge_reg <= (h_reg >= knee_ext);
            t_reg  <= T_W'({e_cap, 3'b000}) - T_W'(e_cap) + T_W'(5);
        end
        if (state_reg == S_DIV)
        begin
            q_reg <= div_prod[HYDRO_W+34:35];
        end
        if (fin_go)
        begin
            hydro_reg    <= hydro_fin;
            out_bad_reg  <= bad_reg;
            out_long_reg <= long_reg;
        end
    end

    assign result_out.valid      = out_valid_reg;
    assign result_out.hydro_q16  = hydro_reg;
    assign result_out.bad_letter = out_bad_reg;
    assign result_out.too_long   = out_long_reg;

    a_mul_after_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MUL) |-> ($past(state_reg) == S_IDLE))
        else $error("multiply step entered without a pop");

    a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_FIN))
        else $error("result appeared outside the final step");

    a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_valid_reg && !result_out.ready) |=>
        (state_reg == S_FIN && $stable(h_reg) && $stable(q_reg)))
        else $error("final step lost its operands while output was stalled");

endmodule
